// ----- rtl/pfrr_pkg.sv -----
`timescale 1ns / 1ps

package pfrr_pkg;

    // Fixed result field widths
    localparam int PAGE_FIELD_W  = 12;
    localparam int FRAME_FIELD_W = 8;

    typedef enum logic [2:0] {
        CMD_SWAP_OUT = 3'd0,
        CMD_TLB_DEL  = 3'd1,
        CMD_SWAP_IN  = 3'd2,
        CMD_TLB_ADD  = 3'd3,
        CMD_ERROR    = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t                     command;
        logic [PAGE_FIELD_W-1:0]  virtual_page;
        logic [FRAME_FIELD_W-1:0] physical_frame;
        logic                     last;
    } out_item_t;

endpackage

// ----- rtl/page_fault_round_robin_pager_unit.sv -----
`timescale 1ns / 1ps

// Demand-paging fault handler with round-robin frame replacement.
// s_ channel: one request per page-fault address (s_tdata). m_ channel: the
// commands it causes, swap out / tlb delete / swap in / tlb add or address
// error in m_tuser, page and frame in m_tdata, m_tlast on the final command.
// cfg_ channel: write of the virtual window base, always ready; write it only
// while no request is in flight.
// Flow: a request is range-checked as it is accepted and enters a two-entry
// queue; the back-end sequencer then reads the table and sends the commands.
// A hit sends only tlb add, an address error only the error command, a miss
// on a free frame swap in and tlb add, and a miss that evicts all four.
// The sequencer takes the next request only after the current one's last
// command, and issues one command per cycle through the output register
// while m_tready is high, which sets the sustained rate.
// Reset: the virtual-to-physical table is cleared by a pass over all its
// VIRTUAL_PAGES entries after aresetn rises; s_tready stays low until done.
// Frame valid bits clear at once, the victim pointer restarts at frame 1.
// Stall: if m_tready is low the current command holds, the sequencer waits,
// and the queue absorbs up to two more requests before s_tready drops.

module page_fault_round_robin_pager_unit import pfrr_pkg::*; #(
    parameter int VIRTUAL_PAGES   = 4096,
    parameter int PHYSICAL_FRAMES = 256,
    parameter int PAGE_SHIFT      = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: virtual_base
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // fault requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] fault_address
    // commands
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [11:0] virtual_page, [19:12] physical_frame, pad
    output logic [2:0]  m_tuser,    // [2:0] command
    output logic        m_tlast
);

    localparam int VW = $clog2(VIRTUAL_PAGES);

    logic [31:0] virtual_base_reg;
    logic        init_busy;
    logic        push_valid, push_ready;
    logic [VW:0] push_data;
    logic        pop_valid, pop_ready;
    logic [VW:0] pop_data;
    out_item_t   out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            virtual_base_reg <= '0;
        end else if (cfg_valid) begin
            virtual_base_reg <= cfg_data;
        end
    end

    // Front end: window check and page extraction
    pfrr_front #(
        .VIRTUAL_PAGES (VIRTUAL_PAGES),
        .PAGE_SHIFT    (PAGE_SHIFT)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .virtual_base (virtual_base_reg),
        .enable       (!init_busy),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // Decoupling queue between range check and sequencer
    pfrr_fifo #(
        .WIDTH (VW + 1)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: table lookup, replacement and command sequencing
    pfrr_back #(
        .VIRTUAL_PAGES   (VIRTUAL_PAGES),
        .PHYSICAL_FRAMES (PHYSICAL_FRAMES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .init_busy (init_busy),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (out_item)
    );

    assign m_tdata = {4'b0000, out_item.physical_frame, out_item.virtual_page};
    assign m_tuser = out_item.command;
    assign m_tlast = out_item.last;

endmodule

// ----- rtl/pfrr_front.sv -----
`timescale 1ns / 1ps

module pfrr_front import pfrr_pkg::*; #(
    parameter int VIRTUAL_PAGES = 4096,
    parameter int PAGE_SHIFT    = 12
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,
    input  logic [31:0]                       virtual_base,
    input  logic                              enable,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [$clog2(VIRTUAL_PAGES):0]    push_data   // {error, page}
);

    localparam int VW = $clog2(VIRTUAL_PAGES);

    logic [32:0] diff;
    logic [31:0] page_wide;
    logic        borrow;
    logic        out_of_range;

    // Offset from window base; borrow means address below base
    assign diff         = {1'b0, s_tdata} - {1'b0, virtual_base};
    assign borrow       = diff[32];
    assign page_wide    = diff[31:0] >> PAGE_SHIFT;
    assign out_of_range = borrow || (page_wide >= 32'(VIRTUAL_PAGES));

    assign push_data  = {out_of_range, page_wide[VW-1:0]};
    assign push_valid = s_tvalid && enable;
    assign s_tready   = push_ready && enable;

endmodule

// ----- rtl/pfrr_fifo.sv -----
`timescale 1ns / 1ps

module pfrr_fifo import pfrr_pkg::*; #(
    parameter int WIDTH = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/pfrr_back.sv -----
`timescale 1ns / 1ps

module pfrr_back import pfrr_pkg::*; #(
    parameter int VIRTUAL_PAGES   = 4096,
    parameter int PHYSICAL_FRAMES = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [$clog2(VIRTUAL_PAGES):0] q_data,   // {error, page}
    output logic                           init_busy,
    output logic                           m_valid,
    input  logic                           m_ready,
    output out_item_t                      m_item
);

    localparam int VW = $clog2(VIRTUAL_PAGES);
    localparam int FW = $clog2(PHYSICAL_FRAMES);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_ERR, ST_LOOK, ST_DEL, ST_IN, ST_ADD
    } state_t;

    state_t          state_reg;
    logic [VW-1:0]   clr_cnt_reg;
    logic [FW-1:0]   victim_reg, victim_next;
    logic [VW-1:0]   page_reg;
    logic [VW-1:0]   old_page_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    // virt_to_phys entry: {mapped, frame}
    logic [FW:0]     vtp_mem [VIRTUAL_PAGES];
    logic [FW:0]     vtp_rd_reg;
    logic [VW-1:0]   ptv_page_mem [PHYSICAL_FRAMES];
    logic [VW-1:0]   ptv_rd_reg;
    logic            ptv_valid_reg [PHYSICAL_FRAMES];

    logic            can_load;
    logic            hit;
    logic            occupied;
    logic            q_err;
    logic [VW-1:0]   q_page;
    logic            vtp_we;
    logic [VW-1:0]   vtp_waddr;
    logic [FW:0]     vtp_wdata;
    logic            ptv_set;
    logic            ptv_clr;

    function automatic logic [PAGE_FIELD_W-1:0] page_field(input logic [VW-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[PAGE_FIELD_W-1:0];
    endfunction

    assign q_err     = q_data[VW];
    assign q_page    = q_data[VW-1:0];
    assign can_load  = !out_valid_reg || m_ready;
    assign hit       = vtp_rd_reg[FW];
    assign occupied  = ptv_valid_reg[victim_reg];
    assign q_ready   = (state_reg == ST_IDLE);
    assign init_busy = (state_reg == ST_INIT);
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    assign victim_next = (victim_reg == FW'(PHYSICAL_FRAMES - 1)) ? FW'(1)
                                                                  : victim_reg + FW'(1);

    // Table write port selection
    always_comb begin
        vtp_we    = 1'b0;
        vtp_waddr = page_reg;
        vtp_wdata = {1'b1, victim_reg};
        ptv_set   = 1'b0;
        ptv_clr   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                vtp_we    = 1'b1;
                vtp_waddr = clr_cnt_reg;
                vtp_wdata = '0;
            end
            ST_LOOK: begin
                if (can_load && !hit) begin
                    vtp_we = 1'b1;
                    if (occupied) begin
                        vtp_waddr = ptv_rd_reg;
                        vtp_wdata = '0;
                        ptv_clr   = 1'b1;
                    end else begin
                        ptv_set = 1'b1;
                    end
                end
            end
            ST_IN: begin
                if (can_load) begin
                    vtp_we  = 1'b1;
                    ptv_set = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (vtp_we) begin
            vtp_mem[vtp_waddr] <= vtp_wdata;
        end
        if (ptv_set) begin
            ptv_page_mem[victim_reg] <= page_reg;
        end
        if (state_reg == ST_IDLE && q_valid) begin
            vtp_rd_reg <= vtp_mem[q_page];
            ptv_rd_reg <= ptv_page_mem[victim_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PHYSICAL_FRAMES; i++) begin
                ptv_valid_reg[i] <= 1'b0;
            end
        end else if (ptv_set) begin
            ptv_valid_reg[victim_reg] <= 1'b1;
        end else if (ptv_clr) begin
            ptv_valid_reg[victim_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            victim_reg    <= FW'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    clr_cnt_reg <= clr_cnt_reg + VW'(1);
                    if (clr_cnt_reg == VW'(VIRTUAL_PAGES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        page_reg  <= q_page;
                        state_reg <= q_err ? ST_ERR : ST_LOOK;
                    end
                end
                ST_ERR: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{CMD_ERROR, '0, '0, 1'b1};
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_LOOK: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        if (hit) begin
                            out_item_reg <= '{CMD_TLB_ADD, page_field(page_reg),
                                              FRAME_FIELD_W'(vtp_rd_reg[FW-1:0]), 1'b1};
                            state_reg    <= ST_IDLE;
                        end else if (occupied) begin
                            old_page_reg <= ptv_rd_reg;
                            out_item_reg <= '{CMD_SWAP_OUT, page_field(ptv_rd_reg),
                                              FRAME_FIELD_W'(victim_reg), 1'b0};
                            state_reg    <= ST_DEL;
                        end else begin
                            out_item_reg <= '{CMD_SWAP_IN, page_field(page_reg),
                                              FRAME_FIELD_W'(victim_reg), 1'b0};
                            state_reg    <= ST_ADD;
                        end
                    end
                end
                ST_DEL: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{CMD_TLB_DEL, page_field(old_page_reg),
                                           FRAME_FIELD_W'(victim_reg), 1'b0};
                        state_reg     <= ST_IN;
                    end
                end
                ST_IN: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{CMD_SWAP_IN, page_field(page_reg),
                                           FRAME_FIELD_W'(victim_reg), 1'b0};
                        state_reg     <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (can_load) begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= '{CMD_TLB_ADD, page_field(page_reg),
                                           FRAME_FIELD_W'(victim_reg), 1'b1};
                        victim_reg    <= victim_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Nothing leaves while the table is being cleared
    a_no_out_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !out_valid_reg)
        else $error("result presented during table clear");

    // Victim pointer stays in 1 .. frames-1
    a_victim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (victim_reg != '0) && (32'(victim_reg) < 32'(PHYSICAL_FRAMES)))
        else $error("victim pointer out of range");

    // Frame 0 is never handed out
    a_frame0_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !ptv_valid_reg[0])
        else $error("frame 0 mapped");

    // last marks exactly the closing command of a request
    a_last_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_item_reg.last ==
            ((out_item_reg.command == CMD_TLB_ADD) || (out_item_reg.command == CMD_ERROR))))
        else $error("last flag does not match command");

endmodule
